// ===== rtl/indexed_list_queue_core_macros.svh =====
// Assertion helpers for the indexed list queue.
// Both sample on the rising edge of clk and stay off while rst_n is low.
`ifndef INDEXED_LIST_QUEUE_CORE_MACROS_SVH
`define INDEXED_LIST_QUEUE_CORE_MACROS_SVH

// Same-cycle implication.
`define ILQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ILQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/ilq_pkg.sv =====
`timescale 1ns / 1ps

package ilq_pkg;

    localparam int ILQ_DEPTH      = 16;
    localparam int ILQ_DATA_WIDTH = 32;

    localparam int OPCODE_W = 3;
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 5;
    localparam int LEN_W    = 5;
    localparam int STATUS_W = 2;

    typedef enum logic [OPCODE_W-1:0] {
        OP_PUSH      = 3'd0,
        OP_POP       = 3'd1,
        OP_INSERT    = 3'd2,
        OP_REMOVE    = 3'd3,
        OP_PEEK_AT   = 3'd4,
        OP_PEEK_HEAD = 3'd5,
        OP_REVERSE   = 3'd6,
        OP_CLEAR     = 3'd7
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_CLAMP = 2'd3
    } status_t;

endpackage

// ===== rtl/indexed_list_queue_core.sv =====
`timescale 1ns / 1ps
// Push, clear, append, single-entry reverse and any full or empty case finish straight from idle;
// pop and peek wait for one RAM read; insert and remove walk the tail and reverse swaps pairs,
// with one entry moved per cycle through the single RAM write port.
// Back-to-back: the next beat is taken in the cycle its predecessor shows done, so a new command
// cannot start while an operation is still busy.
// Reset (rst_n low, async) empties the list; entry RAM contents stay undefined, no sweep.
// Results are one-cycle done strobes; the receiver cannot stall.

module indexed_list_queue_core #(
    parameter int DEPTH      = ilq_pkg::ILQ_DEPTH,
    parameter int DATA_WIDTH = ilq_pkg::ILQ_DATA_WIDTH
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [ilq_pkg::OPCODE_W-1:0] opcode,
    input  logic [ilq_pkg::VALUE_W-1:0]  value,
    input  logic [ilq_pkg::POS_W-1:0]    position,
    output logic                         done,
    output logic [ilq_pkg::VALUE_W-1:0]  result_value,
    output logic [ilq_pkg::LEN_W-1:0]    length,
    output logic [ilq_pkg::STATUS_W-1:0] status
);

    import ilq_pkg::*;

    // AW addresses the RAM, CW holds a count up to DEPTH, PW compares count with position.
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = (CW > POS_W) ? CW : POS_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD_WAIT,
        S_REM_MOVE,
        S_INS_MOVE,
        S_INS_PUT,
        S_REV_A,
        S_REV_B,
        S_REV_C
    } state_t;

    // The list lives in a ring: logical position p sits at (head + p) mod DEPTH.
    // Pop just advances head; insert, remove and reverse move words through the RAM.
    function automatic logic [AW-1:0] phys(input logic [AW-1:0] base,
                                           input logic [CW-1:0] lidx);
        logic [AW+1:0] sum;
        sum = (AW+2)'(base) + (AW+2)'(lidx);
        if (sum >= (AW+2)'(DEPTH))
        begin
            sum = sum - (AW+2)'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    // Control state
    state_t            state_reg,  state_next;
    logic [CW-1:0]     count_reg,  count_next;
    logic [AW-1:0]     head_reg,   head_next;
    opcode_t           op_reg,     op_next;
    status_t           st_reg,     st_next;
    // Walk pointers: src is the word being moved (lo side for reverse), hi the far side.
    logic [CW-1:0]     src_reg,    src_next;
    logic [CW-1:0]     hi_reg,     hi_next;
    logic [CW-1:0]     idx_reg,    idx_next;
    // Payload holding
    logic [DATA_WIDTH-1:0] data_reg, data_next;
    logic [DATA_WIDTH-1:0] hold_reg, hold_next;
    // Result beat
    logic                  done_reg,         done_next;
    logic [VALUE_W-1:0]    result_value_reg, result_value_next;
    logic [LEN_W-1:0]      length_reg,       length_next;
    status_t               status_reg,       status_next;

    // Entry RAM port
    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [AW-1:0]         ram_raddr;
    logic [DATA_WIDTH-1:0] ram_wdata;
    logic [DATA_WIDTH-1:0] ram_rdata;

    ilq_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_entries (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        logic [PW-1:0]         cnt_w;
        logic [PW-1:0]         pos_w;
        logic [CW-1:0]         last;
        logic [CW-1:0]         sel;
        logic                  fin;
        logic [DATA_WIDTH-1:0] fin_value;
        status_t               fin_status;

        cnt_w      = PW'(count_reg);
        pos_w      = PW'(position);
        last       = count_reg - CW'(1);
        sel        = '0;
        fin        = 1'b0;
        fin_value  = '0;
        fin_status = ST_OK;

        state_next = state_reg;
        count_next = count_reg;
        head_next  = head_reg;
        op_next    = op_reg;
        st_next    = st_reg;
        src_next   = src_reg;
        hi_next    = hi_reg;
        idx_next   = idx_reg;
        data_next  = data_reg;
        hold_next  = hold_reg;

        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = data_reg;
        ram_raddr = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next   = opcode_t'(opcode);
                    data_next = DATA_WIDTH'(value);
                    st_next   = ST_OK;
                    case (opcode_t'(opcode))
                        OP_PUSH:
                        begin
                            fin = 1'b1;
                            if (count_reg == CW'(DEPTH))
                            begin
                                fin_status = ST_FULL;
                            end
                            else
                            begin
                                ram_we     = 1'b1;
                                ram_waddr  = phys(head_reg, count_reg);
                                ram_wdata  = DATA_WIDTH'(value);
                                count_next = count_reg + CW'(1);
                            end
                        end
                        OP_INSERT:
                        begin
                            if (count_reg == CW'(DEPTH))
                            begin
                                fin        = 1'b1;
                                fin_status = ST_FULL;
                            end
                            else
                            begin
                                // Past the end: append and flag the clamp.
                                if (pos_w > cnt_w)
                                begin
                                    sel     = count_reg;
                                    st_next = ST_CLAMP;
                                end
                                else
                                begin
                                    sel = CW'(pos_w);
                                end
                                if (sel == count_reg)
                                begin
                                    ram_we     = 1'b1;
                                    ram_waddr  = phys(head_reg, count_reg);
                                    ram_wdata  = DATA_WIDTH'(value);
                                    count_next = count_reg + CW'(1);
                                    fin        = 1'b1;
                                    fin_status = st_next;
                                end
                                else
                                begin
                                    // Shift the tail up one, starting from the last word.
                                    idx_next   = sel;
                                    src_next   = last;
                                    ram_raddr  = phys(head_reg, last);
                                    state_next = S_INS_MOVE;
                                end
                            end
                        end
                        OP_POP, OP_PEEK_HEAD:
                        begin
                            if (count_reg == '0)
                            begin
                                fin        = 1'b1;
                                fin_status = ST_EMPTY;
                            end
                            else
                            begin
                                src_next   = '0;
                                ram_raddr  = head_reg;
                                state_next = S_RD_WAIT;
                            end
                        end
                        OP_REMOVE, OP_PEEK_AT:
                        begin
                            if (count_reg == '0)
                            begin
                                fin        = 1'b1;
                                fin_status = ST_EMPTY;
                            end
                            else
                            begin
                                // At or past the end: act on the last word.
                                if (pos_w >= cnt_w)
                                begin
                                    sel     = last;
                                    st_next = ST_CLAMP;
                                end
                                else
                                begin
                                    sel = CW'(pos_w);
                                end
                                src_next   = sel;
                                ram_raddr  = phys(head_reg, sel);
                                state_next = S_RD_WAIT;
                            end
                        end
                        OP_REVERSE:
                        begin
                            if (count_reg == '0)
                            begin
                                fin        = 1'b1;
                                fin_status = ST_EMPTY;
                            end
                            else if (count_reg == CW'(1))
                            begin
                                fin = 1'b1;
                            end
                            else
                            begin
                                src_next   = '0;
                                hi_next    = last;
                                ram_raddr  = head_reg;
                                state_next = S_REV_A;
                            end
                        end
                        OP_CLEAR:
                        begin
                            count_next = '0;
                            head_next  = '0;
                            fin        = 1'b1;
                        end
                        default:
                        begin
                            fin = 1'b1;
                        end
                    endcase
                end
            end

            S_RD_WAIT:
            begin
                case (op_reg)
                    OP_POP:
                    begin
                        // Drop the head by advancing the ring start.
                        head_next  = phys(head_reg, CW'(1));
                        count_next = last;
                        fin        = 1'b1;
                        fin_value  = ram_rdata;
                        fin_status = st_reg;
                        state_next = S_IDLE;
                    end
                    OP_REMOVE:
                    begin
                        if (src_reg == last)
                        begin
                            count_next = last;
                            fin        = 1'b1;
                            fin_value  = ram_rdata;
                            fin_status = st_reg;
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            // Hold the removed word, then pull the tail down.
                            hold_next  = ram_rdata;
                            src_next   = src_reg + CW'(1);
                            ram_raddr  = phys(head_reg, src_reg + CW'(1));
                            state_next = S_REM_MOVE;
                        end
                    end
                    default:
                    begin
                        fin        = 1'b1;
                        fin_value  = ram_rdata;
                        fin_status = st_reg;
                        state_next = S_IDLE;
                    end
                endcase
            end

            S_REM_MOVE:
            begin
                ram_we    = 1'b1;
                ram_waddr = phys(head_reg, src_reg - CW'(1));
                ram_wdata = ram_rdata;
                if (src_reg == last)
                begin
                    count_next = last;
                    fin        = 1'b1;
                    fin_value  = hold_reg;
                    fin_status = st_reg;
                    state_next = S_IDLE;
                end
                else
                begin
                    src_next  = src_reg + CW'(1);
                    ram_raddr = phys(head_reg, src_reg + CW'(1));
                end
            end

            S_INS_MOVE:
            begin
                ram_we    = 1'b1;
                ram_waddr = phys(head_reg, src_reg + CW'(1));
                ram_wdata = ram_rdata;
                if (src_reg == idx_reg)
                begin
                    state_next = S_INS_PUT;
                end
                else
                begin
                    src_next  = src_reg - CW'(1);
                    ram_raddr = phys(head_reg, src_reg - CW'(1));
                end
            end

            S_INS_PUT:
            begin
                ram_we     = 1'b1;
                ram_waddr  = phys(head_reg, idx_reg);
                ram_wdata  = data_reg;
                count_next = count_reg + CW'(1);
                fin        = 1'b1;
                fin_status = st_reg;
                state_next = S_IDLE;
            end

            S_REV_A:
            begin
                // Low word arrives; hold it and fetch the high word.
                hold_next  = ram_rdata;
                ram_raddr  = phys(head_reg, hi_reg);
                state_next = S_REV_B;
            end

            S_REV_B:
            begin
                // High word lands at the low slot; prefetch the next low word if a pair is left.
                ram_we    = 1'b1;
                ram_waddr = phys(head_reg, src_reg);
                ram_wdata = ram_rdata;
                if (src_reg + CW'(2) < hi_reg)
                begin
                    ram_raddr = phys(head_reg, src_reg + CW'(1));
                end
                state_next = S_REV_C;
            end

            S_REV_C:
            begin
                ram_we    = 1'b1;
                ram_waddr = phys(head_reg, hi_reg);
                ram_wdata = hold_reg;
                if (src_reg + CW'(2) < hi_reg)
                begin
                    hold_next  = ram_rdata;
                    ram_raddr  = phys(head_reg, hi_reg - CW'(1));
                    src_next   = src_reg + CW'(1);
                    hi_next    = hi_reg - CW'(1);
                    state_next = S_REV_B;
                end
                else
                begin
                    fin        = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Result beat: length reports the count after the operation.
        done_next         = fin;
        result_value_next = fin ? VALUE_W'(fin_value) : result_value_reg;
        length_next       = fin ? LEN_W'(count_next) : length_reg;
        status_next       = fin ? fin_status : status_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            count_reg        <= '0;
            head_reg         <= '0;
            op_reg           <= OP_PUSH;
            st_reg           <= ST_OK;
            src_reg          <= '0;
            hi_reg           <= '0;
            idx_reg          <= '0;
            data_reg         <= '0;
            hold_reg         <= '0;
            done_reg         <= 1'b0;
            result_value_reg <= '0;
            length_reg       <= '0;
            status_reg       <= ST_OK;
        end
        else
        begin
            state_reg        <= state_next;
            count_reg        <= count_next;
            head_reg         <= head_next;
            op_reg           <= op_next;
            st_reg           <= st_next;
            src_reg          <= src_next;
            hi_reg           <= hi_next;
            idx_reg          <= idx_next;
            data_reg         <= data_next;
            hold_reg         <= hold_next;
            done_reg         <= done_next;
            result_value_reg <= result_value_next;
            length_reg       <= length_next;
            status_reg       <= status_next;
        end
    end

    // Busy is high in every state but idle, so not in the cycle a command is accepted; the done beat itself is idle.
    assign busy         = (state_reg != S_IDLE);
    assign done         = done_reg;
    assign result_value = result_value_reg;
    assign length       = length_reg;
    assign status       = status_reg;

endmodule

// ===== rtl/ilq_ram.sv =====
`timescale 1ns / 1ps

module ilq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/ilq_checker.sv =====
`timescale 1ns / 1ps
`include "indexed_list_queue_core_macros.svh"

module ilq_checker #(
    parameter int DEPTH = ilq_pkg::ILQ_DEPTH
) (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         start,
    input logic                         busy,
    input logic                         done,
    input logic [ilq_pkg::VALUE_W-1:0]  result_value,
    input logic [ilq_pkg::LEN_W-1:0]    length,
    input logic [ilq_pkg::STATUS_W-1:0] status
);

    import ilq_pkg::*;

    // The done beat always comes with the block free for the next command.
    `ILQ_ASSERT_NOW(a_done_not_busy, done, !busy, "done raised while busy")

    // An accepted command either finishes at once or holds busy.
    `ILQ_ASSERT_NEXT(a_accept_progress, start && !busy, busy || done, "accepted command vanished")

    // A dropped push or insert only happens on a full list.
    `ILQ_ASSERT_NOW(a_full_len, done && (status == ST_FULL), length == LEN_W'(DEPTH), "full status with short list")

    // Reads of an empty list give zero and leave it empty.
    `ILQ_ASSERT_NOW(a_empty_zero, done && (status == ST_EMPTY), (result_value == '0) && (length == '0), "empty status with data")

endmodule

bind indexed_list_queue_core ilq_checker #(
    .DEPTH (DEPTH)
) u_ilq_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .done         (done),
    .result_value (result_value),
    .length       (length),
    .status       (status)
);
